FILE: sv/hse_pkg.sv
// shared types, constants and sha-512 helper functions for the hmac-sha512 engine
package hse_pkg;

    localparam int CountW = 64;
    localparam int KeyBytes = 128;
    localparam int PadFill = 112;
    localparam logic [7:0] IPadByte = 8'h36;
    localparam logic [7:0] OPadByte = 8'h5c;
    localparam logic [7:0] MarkByte = 8'h80;
    localparam logic [7:0] ZeroByte = 8'h00;
    localparam logic [6:0] LastRound = 7'd79;

    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_START      = 4'd1;
    localparam logic [3:0] OP_BYTE       = 4'd2;
    localparam logic [3:0] OP_BYTE_NC    = 4'd3;
    localparam logic [3:0] OP_WORD       = 4'd4;
    localparam logic [3:0] OP_KEY_CLEAR  = 4'd5;
    localparam logic [3:0] OP_KEY_BYTE   = 4'd6;
    localparam logic [3:0] OP_KEY_FROM_H = 4'd7;
    localparam logic [3:0] OP_SAVE_INNER = 4'd8;
    localparam logic [3:0] OP_SAVE_MAC   = 4'd9;

    localparam logic [1:0] SRC_KEY    = 2'd0;
    localparam logic [1:0] SRC_INNER  = 2'd1;
    localparam logic [1:0] SRC_LEN_HI = 2'd2;
    localparam logic [1:0] SRC_LEN_LO = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } req_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } dig_item_t;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] data;
        logic [1:0] src;
        logic [3:0] idx;
        logic [7:0] pad;
    } dp_cmd_t;

    typedef struct packed {
        logic        busy;
        logic        fill_at_len;
        logic        key_full;
        logic [63:0] mac_word;
    } dp_stat_t;

    function automatic logic [63:0] start_value(input logic [2:0] i);
        logic [63:0] r;
        begin
            case (i)
                3'd0: r = 64'h6a09e667f3bcc908;
                3'd1: r = 64'hbb67ae8584caa73b;
                3'd2: r = 64'h3c6ef372fe94f82b;
                3'd3: r = 64'ha54ff53a5f1d36f1;
                3'd4: r = 64'h510e527fade682d1;
                3'd5: r = 64'h9b05688c2b3e6c1f;
                3'd6: r = 64'h1f83d9abfb41bd6b;
                default: r = 64'h5be0cd19137e2179;
            endcase
            return r;
        end
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] i);
        logic [63:0] r;
        begin
            case (i)
                7'd0:  r = 64'h428a2f98d728ae22;  7'd1:  r = 64'h7137449123ef65cd;
                7'd2:  r = 64'hb5c0fbcfec4d3b2f;  7'd3:  r = 64'he9b5dba58189dbbc;
                7'd4:  r = 64'h3956c25bf348b538;  7'd5:  r = 64'h59f111f1b605d019;
                7'd6:  r = 64'h923f82a4af194f9b;  7'd7:  r = 64'hab1c5ed5da6d8118;
                7'd8:  r = 64'hd807aa98a3030242;  7'd9:  r = 64'h12835b0145706fbe;
                7'd10: r = 64'h243185be4ee4b28c;  7'd11: r = 64'h550c7dc3d5ffb4e2;
                7'd12: r = 64'h72be5d74f27b896f;  7'd13: r = 64'h80deb1fe3b1696b1;
                7'd14: r = 64'h9bdc06a725c71235;  7'd15: r = 64'hc19bf174cf692694;
                7'd16: r = 64'he49b69c19ef14ad2;  7'd17: r = 64'hefbe4786384f25e3;
                7'd18: r = 64'h0fc19dc68b8cd5b5;  7'd19: r = 64'h240ca1cc77ac9c65;
                7'd20: r = 64'h2de92c6f592b0275;  7'd21: r = 64'h4a7484aa6ea6e483;
                7'd22: r = 64'h5cb0a9dcbd41fbd4;  7'd23: r = 64'h76f988da831153b5;
                7'd24: r = 64'h983e5152ee66dfab;  7'd25: r = 64'ha831c66d2db43210;
                7'd26: r = 64'hb00327c898fb213f;  7'd27: r = 64'hbf597fc7beef0ee4;
                7'd28: r = 64'hc6e00bf33da88fc2;  7'd29: r = 64'hd5a79147930aa725;
                7'd30: r = 64'h06ca6351e003826f;  7'd31: r = 64'h142929670a0e6e70;
                7'd32: r = 64'h27b70a8546d22ffc;  7'd33: r = 64'h2e1b21385c26c926;
                7'd34: r = 64'h4d2c6dfc5ac42aed;  7'd35: r = 64'h53380d139d95b3df;
                7'd36: r = 64'h650a73548baf63de;  7'd37: r = 64'h766a0abb3c77b2a8;
                7'd38: r = 64'h81c2c92e47edaee6;  7'd39: r = 64'h92722c851482353b;
                7'd40: r = 64'ha2bfe8a14cf10364;  7'd41: r = 64'ha81a664bbc423001;
                7'd42: r = 64'hc24b8b70d0f89791;  7'd43: r = 64'hc76c51a30654be30;
                7'd44: r = 64'hd192e819d6ef5218;  7'd45: r = 64'hd69906245565a910;
                7'd46: r = 64'hf40e35855771202a;  7'd47: r = 64'h106aa07032bbd1b8;
                7'd48: r = 64'h19a4c116b8d2d0c8;  7'd49: r = 64'h1e376c085141ab53;
                7'd50: r = 64'h2748774cdf8eeb99;  7'd51: r = 64'h34b0bcb5e19b48a8;
                7'd52: r = 64'h391c0cb3c5c95a63;  7'd53: r = 64'h4ed8aa4ae3418acb;
                7'd54: r = 64'h5b9cca4f7763e373;  7'd55: r = 64'h682e6ff3d6b2b8a3;
                7'd56: r = 64'h748f82ee5defb2fc;  7'd57: r = 64'h78a5636f43172f60;
                7'd58: r = 64'h84c87814a1f0ab72;  7'd59: r = 64'h8cc702081a6439ec;
                7'd60: r = 64'h90befffa23631e28;  7'd61: r = 64'ha4506cebde82bde9;
                7'd62: r = 64'hbef9a3f7b2c67915;  7'd63: r = 64'hc67178f2e372532b;
                7'd64: r = 64'hca273eceea26619c;  7'd65: r = 64'hd186b8c721c0c207;
                7'd66: r = 64'heada7dd6cde0eb1e;  7'd67: r = 64'hf57d4f7fee6ed178;
                7'd68: r = 64'h06f067aa72176fba;  7'd69: r = 64'h0a637dc5a2c898a6;
                7'd70: r = 64'h113f9804bef90dae;  7'd71: r = 64'h1b710b35131c471b;
                7'd72: r = 64'h28db77f523047d84;  7'd73: r = 64'h32caab7b40c72493;
                7'd74: r = 64'h3c9ebe0a15c9bebc;  7'd75: r = 64'h431d67c49c100d4c;
                7'd76: r = 64'h4cc5d4becb3e42b6;  7'd77: r = 64'h597f299cfc657e2a;
                7'd78: r = 64'h5fcb6fab3ad6faec;  7'd79: r = 64'h6c44198c4a475817;
                default: r = 64'h0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [63:0] big_s0(input logic [63:0] x);
        return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
    endfunction

    function automatic logic [63:0] big_s1(input logic [63:0] x);
        return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
    endfunction

    function automatic logic [63:0] small_s0(input logic [63:0] x);
        return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
    endfunction

    function automatic logic [63:0] small_s1(input logic [63:0] x);
        return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
    endfunction

endpackage

FILE: sv/hmac_sha512_engine_core.sv
// top level of the hmac-sha512 engine: sequencer plus hash datapath
//
//  channel  | signals                          | direction | carries
//  request  | req_valid, req_ready, req_data   | in        | key or message byte, last flag
//  digest   | dig_valid, dig_ready, dig_data   | out       | one 64-bit mac word per transfer
//
// one request at a time, whether a held key byte or a hashed byte; a byte that fills a
// 128-byte block adds a compression (80 rounds, one per cycle, then the chaining add);
// closing a key run feeds the ipad block; closing a message takes 4 or 5 compressions
// plus feed and padding steps before the 8 digest words
// req_ready is low while an item or its digest words are in flight
// reset clears the key to empty and puts the block in key loading
module hmac_sha512_engine_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  hse_pkg::req_item_t req_data,
    output logic               dig_valid,
    input  logic               dig_ready,
    output hse_pkg::dig_item_t dig_data
);

    hse_pkg::dp_cmd_t  cmd;
    hse_pkg::dp_stat_t stat;

    hse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .dig_valid (dig_valid),
        .dig_ready (dig_ready),
        .dig_data  (dig_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    hse_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

FILE: sv/hse_datapath.sv
// hash datapath: key store, block window, sha-512 round unit and digest registers
module hse_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  hse_pkg::dp_cmd_t cmd,
    output hse_pkg::dp_stat_t stat
);

    logic [63:0] key_reg [16];
    logic [7:0]  key_len_reg;
    logic [63:0] inner_reg [8];
    logic [63:0] mac_reg [8];
    logic [63:0] h_reg [8];
    logic [63:0] v_reg [8];
    logic [63:0] w_reg [16];
    logic [55:0] acc_reg;
    logic [6:0]  fill_reg;
    logic [hse_pkg::CountW-1:0] count_reg;
    logic [6:0]  round_reg;
    logic        comp_reg;
    logic        add_reg;

    logic [63:0] cnt64;
    logic [63:0] word_in;
    logic [63:0] byte_word;
    logic [63:0] w_new;
    logic [63:0] t1;
    logic [63:0] t2;
    logic        byte_op;
    logic        word_op;

    assign cnt64 = 64'(count_reg);
    assign byte_op = (cmd.op == hse_pkg::OP_BYTE) || (cmd.op == hse_pkg::OP_BYTE_NC);
    assign word_op = (cmd.op == hse_pkg::OP_WORD);
    assign byte_word = {acc_reg, cmd.data};

    always_comb
    begin
        case (cmd.src)
            hse_pkg::SRC_KEY:    word_in = key_reg[cmd.idx] ^ {8{cmd.pad}};
            hse_pkg::SRC_INNER:  word_in = inner_reg[cmd.idx[2:0]];
            hse_pkg::SRC_LEN_HI: word_in = cnt64 >> 61;
            default:             word_in = cnt64 << 3;
        endcase
    end

    assign w_new = hse_pkg::small_s1(w_reg[14]) + w_reg[9]
                 + hse_pkg::small_s0(w_reg[1]) + w_reg[0];
    assign t1 = v_reg[7] + hse_pkg::big_s1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + hse_pkg::round_k(round_reg) + w_reg[0];
    assign t2 = hse_pkg::big_s0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign stat.busy = comp_reg | add_reg;
    assign stat.fill_at_len = (fill_reg == 7'(hse_pkg::PadFill));
    assign stat.key_full = (key_len_reg == 8'(hse_pkg::KeyBytes));
    assign stat.mac_word = mac_reg[cmd.idx[2:0]];

    // control and key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            count_reg <= '0;
            comp_reg <= 1'b0;
            add_reg <= 1'b0;
            round_reg <= '0;
            key_len_reg <= '0;
            for (int i = 0; i < 16; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else
        begin
            if (comp_reg)
            begin
                round_reg <= round_reg + 7'd1;
                if (round_reg == hse_pkg::LastRound)
                begin
                    comp_reg <= 1'b0;
                    add_reg <= 1'b1;
                end
            end
            if (add_reg)
            begin
                add_reg <= 1'b0;
            end
            case (cmd.op)
                hse_pkg::OP_START:
                begin
                    fill_reg <= '0;
                    count_reg <= '0;
                end
                hse_pkg::OP_BYTE, hse_pkg::OP_BYTE_NC:
                begin
                    fill_reg <= fill_reg + 7'd1;
                    if (cmd.op == hse_pkg::OP_BYTE)
                    begin
                        count_reg <= count_reg + hse_pkg::CountW'(1);
                    end
                    if (fill_reg == 7'd127)
                    begin
                        comp_reg <= 1'b1;
                        round_reg <= '0;
                    end
                end
                hse_pkg::OP_WORD:
                begin
                    fill_reg <= fill_reg + 7'd8;
                    // length words are padding and stay out of the count
                    if ((cmd.src != hse_pkg::SRC_LEN_HI) && (cmd.src != hse_pkg::SRC_LEN_LO))
                    begin
                        count_reg <= count_reg + hse_pkg::CountW'(8);
                    end
                    if (fill_reg == 7'd120)
                    begin
                        comp_reg <= 1'b1;
                        round_reg <= '0;
                    end
                end
                hse_pkg::OP_KEY_CLEAR:
                begin
                    key_len_reg <= '0;
                    for (int i = 0; i < 16; i++)
                    begin
                        key_reg[i] <= '0;
                    end
                end
                hse_pkg::OP_KEY_BYTE:
                begin
                    key_len_reg <= key_len_reg + 8'd1;
                    key_reg[key_len_reg[6:3]][8 * (7 - int'(key_len_reg[2:0])) +: 8]
                        <= cmd.data;
                end
                hse_pkg::OP_KEY_FROM_H:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        key_reg[i] <= h_reg[i];
                        key_reg[i + 8] <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // hash payload registers
    always_ff @(posedge clk)
    begin
        if (comp_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
        else if (byte_op || word_op)
        begin
            if (byte_op)
            begin
                acc_reg <= byte_word[55:0];
            end
            if (word_op || (fill_reg[2:0] == 3'd7))
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= word_op ? word_in : byte_word;
            end
            // block complete: load working variables
            if ((byte_op && fill_reg == 7'd127) || (word_op && fill_reg == 7'd120))
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
        end
        if (add_reg)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
        else if (cmd.op == hse_pkg::OP_START)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= hse_pkg::start_value(3'(i));
            end
        end
        if (cmd.op == hse_pkg::OP_SAVE_INNER)
        begin
            for (int i = 0; i < 8; i++)
            begin
                inner_reg[i] <= h_reg[i];
            end
        end
        if (cmd.op == hse_pkg::OP_SAVE_MAC)
        begin
            for (int i = 0; i < 8; i++)
            begin
                mac_reg[i] <= h_reg[i];
            end
        end
    end

endmodule

FILE: sv/hse_ctrl.sv
// sequencer for key loading, message hashing, padding and digest output
module hse_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  hse_pkg::req_item_t req_data,
    output logic               dig_valid,
    input  logic               dig_ready,
    output hse_pkg::dig_item_t dig_data,
    output hse_pkg::dp_cmd_t   cmd,
    input  hse_pkg::dp_stat_t  stat
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_KBYTE  = 4'd2;
    localparam logic [3:0] S_KLAST  = 4'd3;
    localparam logic [3:0] S_MBYTE  = 4'd4;
    localparam logic [3:0] S_MLAST  = 4'd5;
    localparam logic [3:0] S_PSTART = 4'd6;
    localparam logic [3:0] S_PFEED  = 4'd7;
    localparam logic [3:0] S_PWAIT  = 4'd8;
    localparam logic [3:0] S_IFEED  = 4'd9;
    localparam logic [3:0] S_F80    = 4'd10;
    localparam logic [3:0] S_FZ     = 4'd11;
    localparam logic [3:0] S_FHI    = 4'd12;
    localparam logic [3:0] S_FLO    = 4'd13;
    localparam logic [3:0] S_FWAIT  = 4'd14;
    localparam logic [3:0] S_EMIT   = 4'd15;

    localparam logic [2:0] JB_LONG      = 3'd0;
    localparam logic [2:0] JB_KEY_IPAD  = 3'd1;
    localparam logic [2:0] JB_OPAD      = 3'd2;
    localparam logic [2:0] JB_RE_IPAD   = 3'd3;
    localparam logic [2:0] JB_FIN_KEY   = 3'd4;
    localparam logic [2:0] JB_FIN_INNER = 3'd5;
    localparam logic [2:0] JB_FIN_OUTER = 3'd6;

    logic [3:0] state_reg, state_next;
    logic [2:0] job_reg, job_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [7:0] pad_reg, pad_next;
    logic       phase_reg, phase_next;
    logic       long_reg, long_next;
    hse_pkg::req_item_t item_reg;

    assign req_ready = (state_reg == S_IDLE);
    assign dig_valid = (state_reg == S_EMIT);
    assign dig_data.digest_word = stat.mac_word;
    assign dig_data.word_index = cnt_reg[2:0];
    assign dig_data.last_word = (cnt_reg[2:0] == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        job_next = job_reg;
        cnt_next = cnt_reg;
        pad_next = pad_reg;
        phase_next = phase_reg;
        long_next = long_reg;
        cmd.op = hse_pkg::OP_NONE;
        cmd.data = item_reg.data_byte;
        cmd.src = hse_pkg::SRC_KEY;
        cmd.idx = cnt_reg;
        cmd.pad = pad_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!item_reg.req_type)
                begin
                    if (phase_reg)
                    begin
                        // key request in the message phase: start a fresh key
                        cmd.op = hse_pkg::OP_KEY_CLEAR;
                        phase_next = 1'b0;
                        long_next = 1'b0;
                    end
                    else if (!item_reg.byte_valid)
                    begin
                        state_next = S_KLAST;
                    end
                    else if (long_reg)
                    begin
                        state_next = S_KBYTE;
                    end
                    else if (!stat.key_full)
                    begin
                        cmd.op = hse_pkg::OP_KEY_BYTE;
                        state_next = S_KLAST;
                    end
                    else
                    begin
                        long_next = 1'b1;
                        job_next = JB_LONG;
                        pad_next = hse_pkg::ZeroByte;
                        state_next = S_PSTART;
                    end
                end
                else if (!phase_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = item_reg.byte_valid ? S_MBYTE : S_MLAST;
                end
            end
            S_KBYTE, S_MBYTE:
            begin
                if (!stat.busy)
                begin
                    cmd.op = hse_pkg::OP_BYTE;
                    state_next = (state_reg == S_KBYTE) ? S_KLAST : S_MLAST;
                end
            end
            S_KLAST:
            begin
                if (!stat.busy)
                begin
                    if (!item_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (long_reg)
                    begin
                        job_next = JB_FIN_KEY;
                        state_next = S_F80;
                    end
                    else
                    begin
                        job_next = JB_KEY_IPAD;
                        pad_next = hse_pkg::IPadByte;
                        state_next = S_PSTART;
                    end
                end
            end
            S_MLAST:
            begin
                if (!stat.busy)
                begin
                    if (!item_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        job_next = JB_FIN_INNER;
                        state_next = S_F80;
                    end
                end
            end
            S_PSTART:
            begin
                cmd.op = hse_pkg::OP_START;
                cnt_next = '0;
                state_next = S_PFEED;
            end
            S_PFEED:
            begin
                if (!stat.busy)
                begin
                    cmd.op = hse_pkg::OP_WORD;
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        state_next = S_PWAIT;
                    end
                end
            end
            S_PWAIT:
            begin
                if (!stat.busy)
                begin
                    cnt_next = '0;
                    case (job_reg)
                        JB_LONG:     state_next = S_KBYTE;
                        JB_KEY_IPAD:
                        begin
                            phase_next = 1'b1;
                            state_next = S_IDLE;
                        end
                        JB_OPAD:     state_next = S_IFEED;
                        default:     state_next = S_EMIT;
                    endcase
                end
            end
            S_IFEED:
            begin
                cmd.src = hse_pkg::SRC_INNER;
                if (!stat.busy)
                begin
                    cmd.op = hse_pkg::OP_WORD;
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd7)
                    begin
                        job_next = JB_FIN_OUTER;
                        state_next = S_F80;
                    end
                end
            end
            S_F80:
            begin
                cmd.data = hse_pkg::MarkByte;
                if (!stat.busy)
                begin
                    cmd.op = hse_pkg::OP_BYTE_NC;
                    state_next = S_FZ;
                end
            end
            S_FZ:
            begin
                cmd.data = hse_pkg::ZeroByte;
                if (!stat.busy)
                begin
                    if (stat.fill_at_len)
                    begin
                        state_next = S_FHI;
                    end
                    else
                    begin
                        cmd.op = hse_pkg::OP_BYTE_NC;
                    end
                end
            end
            S_FHI:
            begin
                cmd.op = hse_pkg::OP_WORD;
                cmd.src = hse_pkg::SRC_LEN_HI;
                state_next = S_FLO;
            end
            S_FLO:
            begin
                cmd.op = hse_pkg::OP_WORD;
                cmd.src = hse_pkg::SRC_LEN_LO;
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (!stat.busy)
                begin
                    state_next = S_PSTART;
                    case (job_reg)
                        JB_FIN_KEY:
                        begin
                            cmd.op = hse_pkg::OP_KEY_FROM_H;
                            job_next = JB_KEY_IPAD;
                            pad_next = hse_pkg::IPadByte;
                        end
                        JB_FIN_INNER:
                        begin
                            cmd.op = hse_pkg::OP_SAVE_INNER;
                            job_next = JB_OPAD;
                            pad_next = hse_pkg::OPadByte;
                        end
                        default:
                        begin
                            cmd.op = hse_pkg::OP_SAVE_MAC;
                            job_next = JB_RE_IPAD;
                            pad_next = hse_pkg::IPadByte;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (dig_ready)
                begin
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg[2:0] == 3'd7)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg <= JB_LONG;
            cnt_reg <= '0;
            pad_reg <= '0;
            phase_reg <= 1'b0;
            long_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg <= job_next;
            cnt_reg <= cnt_next;
            pad_reg <= pad_next;
            phase_reg <= phase_next;
            long_reg <= long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req_data;
        end
    end

endmodule

FILE: sv/hse_checker.sv
// port-level checks for the hmac-sha512 engine, bound to the top level
module hse_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input hse_pkg::req_item_t req_data,
    input logic               dig_valid,
    input logic               dig_ready,
    input hse_pkg::dig_item_t dig_data
);

    // no request is taken while digest words are pending
    assert property (@(posedge clk) disable iff (!rst_n) !(req_ready && dig_valid))
        else $error("request accepted during digest output");

    // digest words come in order with no gap
    assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && dig_ready && !dig_data.last_word |=>
        dig_valid && (dig_data.word_index == $past(dig_data.word_index) + 3'd1))
        else $error("digest word sequence broken");

    assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> (dig_data.last_word == (dig_data.word_index == 3'd7)))
        else $error("last word flag mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && !dig_ready |=> dig_valid && $stable(dig_data))
        else $error("stalled digest word changed");

    // after the final word the block returns to taking requests
    assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && dig_ready && dig_data.last_word |=> req_ready)
        else $error("not ready after digest");

endmodule

bind hmac_sha512_engine_core hse_checker u_hse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig_data  (dig_data)
);
